[rtl/icmp_header_parse_and_checksum_defines.svh]
// assertion macros for the checker file
`ifndef ICMP_HEADER_PARSE_AND_CHECKSUM_DEFINES_SVH
`define ICMP_HEADER_PARSE_AND_CHECKSUM_DEFINES_SVH

// clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must hold whenever a result word is offered
`define ASSERT_OUT(label, cond, msg) \
    `ASSERT_CLK(label, out_valid |-> (cond), msg)

`endif

[rtl/icmp_hpc_pkg.sv]
// ----------------------------------------------------------------------------
// icmp_hpc_pkg
// Constants and type classification helpers for the ICMP header parser.
// ----------------------------------------------------------------------------
package icmp_hpc_pkg;

    // byte counter and header geometry
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] MAX_PACKET_BYTES = 16'd65535;
    localparam logic [CNT_W-1:0] HDR_BYTES = 16'd8;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

    // register map
    localparam int PADDR_W = 3;

    // types accepted for the selected mode
    function automatic logic type_valid(input logic [7:0] t, input logic v6);
        logic ok;
        if (v6)
        begin
            ok = (t >= 8'd1 && t <= 8'd4) || (t >= 8'd128 && t <= 8'd137);
        end
        else
        begin
            ok = (t <= 8'd18) || (t == 8'd30);
        end
        return ok;
    endfunction

    // error message types
    function automatic logic type_error(input logic [7:0] t, input logic v6);
        logic err;
        if (v6)
        begin
            err = (t >= 8'd1 && t <= 8'd4);
        end
        else
        begin
            err = (t == 8'd3) || (t == 8'd4) || (t == 8'd5) || (t == 8'd11) ||
                  (t == 8'd12);
        end
        return err;
    endfunction

    // informational message types
    function automatic logic type_info(input logic [7:0] t, input logic v6);
        logic inf;
        if (v6)
        begin
            inf = (t >= 8'd128 && t <= 8'd137);
        end
        else
        begin
            inf = (t == 8'd0) || (t == 8'd8) || (t == 8'd13) || (t == 8'd14) ||
                  (t == 8'd15) || (t == 8'd16);
        end
        return inf;
    endfunction

endpackage

[rtl/icmp_header_parse_and_checksum.sv]
// ----------------------------------------------------------------------------
// icmp_header_parse_and_checksum
// Byte-serial ICMP header capture with Internet checksum check.
// ----------------------------------------------------------------------------
// Input channel: one message byte per word (data_byte), last_byte marks the
// final byte. Output channel: one result word per message, offered on the
// cycle after the final byte is taken, holding the header fields, payload
// length, status, checksum check and type class.
// Throughput is one byte per cycle unless a waiting result holds in_ready
// low: bytes are summed in pairs, each pair passing through one 16-bit ones'
// complement add into the running-sum register, and the final result is
// formed by the same add plus a compare into the output register.
// The output register parts the two sides: while a result waits, in_ready
// stays high only if out_ready is high, so a stalled receiver holds the
// result steady and back-pressures the byte stream.
// Reset clears the per-message state, ipv6_mode and the output valid flag;
// no result is pending after reset. The per-message state is cleared again
// as each final byte is taken, so messages may follow back to back.
// ipv6_mode is written through the APB-style port at addresses 0 to 3 (paddr[2] low).
// ----------------------------------------------------------------------------
module icmp_header_parse_and_checksum (
    input  logic                              clk,
    input  logic                              rst_n,
    // config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [icmp_hpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // byte input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        msg_type,
    output logic [7:0]                        msg_code,
    output logic [15:0]                       checksum_field,
    output logic [31:0]                       rest_of_header,
    output logic [15:0]                       payload_len,
    output logic [1:0]                        status,
    output logic                              checksum_ok,
    output logic                              error_class,
    output logic                              info_class
);
    import icmp_hpc_pkg::*;

    logic              ipv6_mode_reg;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        code_reg, code_next;
    logic [15:0]       carried_sum_reg, carried_sum_next;
    logic [31:0]       rest_reg, rest_next;
    logic [15:0]       running_sum_reg, running_sum_next;
    logic [7:0]        pending_high_reg, pending_high_next;
    logic              odd_phase_reg, odd_phase_next;

    logic              out_valid_reg;
    logic [7:0]        msg_type_reg, msg_code_reg;
    logic [15:0]       checksum_field_reg, payload_len_reg;
    logic [31:0]       rest_of_header_reg;
    logic [1:0]        status_reg, status_next;
    logic              checksum_ok_reg, checksum_ok_next;
    logic              error_class_reg, error_class_next;
    logic              info_class_reg, info_class_next;
    logic [15:0]       payload_len_next;

    logic              accept;
    logic              cfg_write;
    logic [15:0]       word;
    logic [16:0]       sum_wide;
    logic [15:0]       sum_fold;
    logic              is_short;

    // config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);
    assign prdata    = (paddr[PADDR_W-1] == 1'b0) ? {31'd0, ipv6_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv6_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            ipv6_mode_reg <= pwdata[0];
        end
    end

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // header capture by byte position
    always_comb
    begin
        type_next        = type_reg;
        code_next        = code_reg;
        carried_sum_next = carried_sum_reg;
        rest_next        = rest_reg;
        if (byte_count_reg < HDR_BYTES)
        begin
            unique case (byte_count_reg[2:0])
                3'd0: type_next = data_byte;
                3'd1: code_next = data_byte;
                3'd2: carried_sum_next[15:8] = data_byte;
                3'd3: carried_sum_next[7:0] = data_byte;
                3'd4: rest_next[31:24] = data_byte;
                3'd5: rest_next[23:16] = data_byte;
                3'd6: rest_next[15:8] = data_byte;
                3'd7: rest_next[7:0] = data_byte;
                default: type_next = type_reg;
            endcase
        end
    end

    // saturating byte count
    assign byte_count_next = (byte_count_reg < MAX_PACKET_BYTES) ?
                             (byte_count_reg + 16'd1) : byte_count_reg;

    // ones' complement add; an unpaired byte goes in as the high half
    assign word     = odd_phase_reg ? {pending_high_reg, data_byte} : {data_byte, 8'h00};
    assign sum_wide = {1'b0, running_sum_reg} + {1'b0, word};
    assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

    assign running_sum_next  = odd_phase_reg ? sum_fold : running_sum_reg;
    assign pending_high_next = odd_phase_reg ? pending_high_reg : data_byte;
    assign odd_phase_next    = !odd_phase_reg;

    // result fields for the final byte
    assign is_short         = byte_count_next < HDR_BYTES;
    assign payload_len_next = byte_count_next - HDR_BYTES;

    always_comb
    begin
        status_next      = STATUS_OK;
        checksum_ok_next = 1'b0;
        error_class_next = 1'b0;
        info_class_next  = 1'b0;
        priority if (is_short)
        begin
            status_next = STATUS_SHORT;
        end
        else if (!type_valid(type_next, ipv6_mode_reg))
        begin
            status_next = STATUS_BAD_TYPE;
        end
        else
        begin
            checksum_ok_next = (payload_len_next == 16'd0) || (sum_fold == 16'hFFFF);
            error_class_next = type_error(type_next, ipv6_mode_reg);
            info_class_next  = type_info(type_next, ipv6_mode_reg);
        end
    end

    // per-message state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            type_reg         <= '0;
            code_reg         <= '0;
            carried_sum_reg  <= '0;
            rest_reg         <= '0;
            running_sum_reg  <= '0;
            pending_high_reg <= '0;
            odd_phase_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_count_reg   <= '0;
                type_reg         <= '0;
                code_reg         <= '0;
                carried_sum_reg  <= '0;
                rest_reg         <= '0;
                running_sum_reg  <= '0;
                pending_high_reg <= '0;
                odd_phase_reg    <= 1'b0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                type_reg         <= type_next;
                code_reg         <= code_next;
                carried_sum_reg  <= carried_sum_next;
                rest_reg         <= rest_next;
                running_sum_reg  <= running_sum_next;
                pending_high_reg <= pending_high_next;
                odd_phase_reg    <= odd_phase_next;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            msg_type_reg       <= type_next;
            msg_code_reg       <= code_next;
            checksum_field_reg <= carried_sum_next;
            rest_of_header_reg <= rest_next;
            payload_len_reg    <= (status_next == STATUS_OK) ? payload_len_next : 16'd0;
            status_reg         <= status_next;
            checksum_ok_reg    <= checksum_ok_next;
            error_class_reg    <= error_class_next;
            info_class_reg     <= info_class_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign msg_type       = msg_type_reg;
    assign msg_code       = msg_code_reg;
    assign checksum_field = checksum_field_reg;
    assign rest_of_header = rest_of_header_reg;
    assign payload_len    = payload_len_reg;
    assign status         = status_reg;
    assign checksum_ok    = checksum_ok_reg;
    assign error_class    = error_class_reg;
    assign info_class     = info_class_reg;

endmodule

[rtl/icmp_hpc_checker.sv]
// ----------------------------------------------------------------------------
// icmp_hpc_checker
// Port-level checks for the ICMP header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "icmp_header_parse_and_checksum_defines.svh"

module icmp_hpc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              last_byte,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [7:0]                        msg_type,
    input  logic [31:0]                       rest_of_header,
    input  logic [15:0]                       payload_len,
    input  logic [1:0]                        status,
    input  logic                              checksum_ok,
    input  logic                              error_class,
    input  logic                              info_class
);
    import icmp_hpc_pkg::*;

    // a stalled result word stays offered and unchanged
    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(msg_type) && $stable(status) && $stable(rest_of_header), "result word changed while stalled")

    // a final byte taken always produces a result next cycle
    `ASSERT_CLK(a_last_gives_result, in_valid && in_ready && last_byte |=> out_valid, "final byte produced no result")

    // failed messages carry no length, checksum or class
    `ASSERT_OUT(a_fail_fields, (status == STATUS_OK) || (payload_len == 16'd0 && !checksum_ok && !error_class && !info_class), "failed message carries derived fields")

    // a type is never both error and informational, and status is a known code
    `ASSERT_OUT(a_class_excl, !(error_class && info_class) && (status == STATUS_OK || status == STATUS_SHORT || status == STATUS_BAD_TYPE), "bad class or status")

endmodule

bind icmp_header_parse_and_checksum icmp_hpc_checker u_icmp_hpc_checker (.*);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-serial ICMP header parser. Messages are
// streamed one byte per word under random sender gaps and receiver stalls.
// A local model of the parser predicts each result word, and a monitor
// compares every result field against the oldest prediction. Covers register
// access, short messages, bad types and checksums in both modes.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import icmp_hpc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 800;

    // register map
    localparam logic [PADDR_W-1:0] ADDR_IPV6_MODE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_SPARE     = 3'd4;

    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_ANY_TYPE, FRAME_SHORT} frame_kind_t;
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_pattern_t;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] checksum_field;
        logic [31:0] rest_of_header;
        logic [15:0] payload_len;
        logic [1:0]  status;
        logic        checksum_ok;
        logic        error_class;
        logic        info_class;
    } icmp_summary_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] checksum_field;
    logic [31:0] rest_of_header;
    logic [15:0] payload_len;
    logic [1:0]  status;
    logic        checksum_ok;
    logic        error_class;
    logic        info_class;

    // parser shadow state
    logic        mode_v6;
    logic [15:0] rx_count;
    logic [7:0]  rx_type;
    logic [7:0]  rx_code;
    logic [15:0] rx_csum;
    logic [31:0] rx_rest;
    logic [15:0] rx_sum;
    logic [7:0]  rx_high;
    logic        rx_odd;

    icmp_summary_t awaited_summaries[$];
    logic [7:0]    frame_bytes[$];
    int            fail_count = 0;
    int            burst_left = 0;
    int            stall_left = 0;
    rx_pattern_t   rx_pattern = RX_FREE;

    icmp_header_parse_and_checksum u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .msg_type       (msg_type),
        .msg_code       (msg_code),
        .checksum_field (checksum_field),
        .rest_of_header (rest_of_header),
        .payload_len    (payload_len),
        .status         (status),
        .checksum_ok    (checksum_ok),
        .error_class    (error_class),
        .info_class     (info_class)
    );

    always #HALF_PERIOD clk = ~clk;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // {accepted, error, info} for a type under the given mode
    function automatic logic [2:0] classify_type(input logic [7:0] t, input logic v6);
        logic acc;
        logic err;
        logic info;
        if (v6)
        begin
            err  = (t >= 8'd1) && (t <= 8'd4);
            info = (t >= 8'd128) && (t <= 8'd137);
            acc  = err || info;
        end
        else
        begin
            err  = 1'b0;
            info = 1'b0;
            case (t)
                8'd3, 8'd4, 8'd5, 8'd11, 8'd12:            err  = 1'b1;
                8'd0, 8'd8, 8'd13, 8'd14, 8'd15, 8'd16:    info = 1'b1;
                default:                                   ;
            endcase
            acc = (t <= 8'd18) || (t == 8'd30);
        end
        return {acc, err, info};
    endfunction

    // clear the per-message shadow state
    task automatic clear_message_shadow();
        rx_count = '0;
        rx_type  = '0;
        rx_code  = '0;
        rx_csum  = '0;
        rx_rest  = '0;
        rx_sum   = '0;
        rx_high  = '0;
        rx_odd   = 1'b0;
    endtask

    // fold one accepted byte into the shadow parser, queue a summary on the last
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        icmp_summary_t r;
        logic [15:0]   total;
        logic [2:0]    cls;
        case (rx_count)
            16'd0: rx_type        = b;
            16'd1: rx_code        = b;
            16'd2: rx_csum[15:8]  = b;
            16'd3: rx_csum[7:0]   = b;
            16'd4: rx_rest[31:24] = b;
            16'd5: rx_rest[23:16] = b;
            16'd6: rx_rest[15:8]  = b;
            16'd7: rx_rest[7:0]   = b;
            default: ;
        endcase
        if (rx_count < MAX_PACKET_BYTES)
        begin
            rx_count = rx_count + 16'd1;
        end
        if (rx_odd)
        begin
            rx_sum = ones_add(rx_sum, {rx_high, b});
            rx_odd = 1'b0;
        end
        else
        begin
            rx_high = b;
            rx_odd  = 1'b1;
        end
        if (fin)
        begin
            total = rx_odd ? ones_add(rx_sum, {rx_high, 8'h00}) : rx_sum;
            cls   = classify_type(rx_type, mode_v6);
            r = '0;
            r.msg_type       = rx_type;
            r.msg_code       = rx_code;
            r.checksum_field = rx_csum;
            r.rest_of_header = rx_rest;
            if (rx_count < HDR_BYTES)
            begin
                r.status = STATUS_SHORT;
            end
            else if (!cls[2])
            begin
                r.status = STATUS_BAD_TYPE;
            end
            else
            begin
                r.status         = STATUS_OK;
                r.payload_len    = rx_count - HDR_BYTES;
                r.checksum_ok    = (r.payload_len == 16'd0) || (total == 16'hFFFF);
                r.error_class    = cls[1];
                r.info_class     = cls[0];
            end
            awaited_summaries.push_back(r);
            clear_message_shadow();
        end
    endtask

    // ones' complement sum over the frame being built, odd tail padded low
    function automatic logic [15:0] frame_sum();
        logic [15:0] s;
        logic [7:0]  lo;
        s = '0;
        for (int i = 0; i < frame_bytes.size(); i += 2)
        begin
            lo = (i + 1 < frame_bytes.size()) ? frame_bytes[i + 1] : 8'h00;
            s  = ones_add(s, {frame_bytes[i], lo});
        end
        return s;
    endfunction

    // header plus random payload, checksum bytes zero
    task automatic build_frame(input logic [7:0] t, input logic [7:0] c,
                               input logic [31:0] rest, input int plen);
        frame_bytes.delete();
        frame_bytes.push_back(t);
        frame_bytes.push_back(c);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(rest[31:24]);
        frame_bytes.push_back(rest[23:16]);
        frame_bytes.push_back(rest[15:8]);
        frame_bytes.push_back(rest[7:0]);
        repeat (plen) frame_bytes.push_back(8'($urandom()));
    endtask

    // fill the checksum field so the whole frame sums to all ones
    task automatic seal_checksum();
        logic [15:0] csum;
        frame_bytes[2] = 8'h00;
        frame_bytes[3] = 8'h00;
        csum = ~frame_sum();
        frame_bytes[2] = csum[15:8];
        frame_bytes[3] = csum[7:0];
    endtask

    function automatic logic [7:0] pick_valid_type(input logic v6);
        int r;
        if (v6)
        begin
            r = $urandom_range(0, 13);
            return (r < 4) ? 8'(r + 1) : 8'(128 + r - 4);
        end
        r = $urandom_range(0, 19);
        return (r == 19) ? 8'd30 : 8'(r);
    endfunction

    // send one byte word; entered and left at a falling edge, valid left high
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do @(posedge clk); while (!in_ready);
        absorb_byte(b, fin);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // stop sending and wait until every predicted word has come out
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (awaited_summaries.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one config transfer: setup cycle then access cycle
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr && addr == ADDR_IPV6_MODE)
        begin
            mode_v6 = wdata[0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] wdata);
        logic [31:0] unused;
        reg_access(1'b1, addr, wdata, unused);
    endtask

    task automatic check_mode_readback();
        logic [31:0] rd;
        reg_access(1'b0, ADDR_IPV6_MODE, 32'd0, rd);
        if (rd !== {31'd0, mode_v6})
        begin
            $display("%0t ipv6_mode readback: expected %0h actual %0h",
                     $realtime, {31'd0, mode_v6}, rd);
            fail_count++;
        end
    endtask

    // reset value, both settings, wide data, writes to an unused slot
    task automatic test_register_access();
        check_mode_readback();
        write_reg(ADDR_IPV6_MODE, 32'hFFFF_FFFF);
        check_mode_readback();
        write_reg(ADDR_SPARE, 32'h0000_0000);
        check_mode_readback();
        write_reg(ADDR_IPV6_MODE, 32'hFFFF_FFFE);
        check_mode_readback();
        write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
        check_mode_readback();
    endtask

    // hand-built messages for the corner cases
    task automatic test_directed_frames();
        // single byte message, all ones
        frame_bytes = '{8'hFF};
        send_frame();
        // header only: checksum forced good even though the field is wrong
        frame_bytes = '{8'd30, 8'hFF, 8'h12, 8'h34, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        // odd length with a one byte payload, zero header
        build_frame(8'd0, 8'd0, 32'd0, 0);
        frame_bytes.push_back(8'hFF);
        seal_checksum();
        send_frame();
        // seven bytes, one short of a header
        frame_bytes = '{8'd3, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h7F, 8'hA5};
        send_frame();
        // v4 echo reply type is not a v6 type
        settle_idle();
        write_reg(ADDR_IPV6_MODE, 32'd1);
        build_frame(8'd0, 8'd0, 32'h0000_0000, 0);
        send_frame();
        settle_idle();
    endtask

    // random traffic over several mode settings
    task automatic test_random_frames();
        logic        phase_mode[4] = '{1'b0, 1'b1, 1'b1, 1'b0};
        logic [31:0] wd;
        int          sent;
        int          plen;
        int          idx;
        frame_kind_t kind;
        int          roll;
        for (int p = 0; p < 4; p++)
        begin
            settle_idle();
            wd    = $urandom();
            wd[0] = phase_mode[p];
            write_reg(ADDR_IPV6_MODE, wd);
            sent = 0;
            while (sent < RANDOM_BYTES / 4)
            begin
                // hold off mid-run, while the byte count is in a 12-byte window, until the result queue drains
                if (p == 2 && sent >= RANDOM_BYTES / 8 && sent < RANDOM_BYTES / 8 + 12)
                begin
                    settle_idle();
                end
                roll = $urandom_range(0, 99);
                kind = (roll < 60) ? FRAME_GOOD : (roll < 75) ? FRAME_BAD_SUM :
                       (roll < 88) ? FRAME_ANY_TYPE : FRAME_SHORT;
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                   : $urandom_range(0, 24);
                case (kind)
                    FRAME_GOOD, FRAME_BAD_SUM:
                    begin
                        build_frame(pick_valid_type(mode_v6), 8'($urandom()),
                                    $urandom(), plen);
                        seal_checksum();
                        if (kind == FRAME_BAD_SUM)
                        begin
                            idx = $urandom_range(0, frame_bytes.size() - 1);
                            frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
                        end
                    end
                    FRAME_ANY_TYPE:
                    begin
                        build_frame(8'($urandom()), 8'($urandom()), $urandom(), plen);
                        if ($urandom_range(0, 1) == 1)
                        begin
                            seal_checksum();
                        end
                    end
                    default:
                    begin
                        frame_bytes.delete();
                        repeat ($urandom_range(1, 7)) frame_bytes.push_back(8'($urandom()));
                    end
                endcase
                send_frame();
                sent += frame_bytes.size();
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t %s: expected %0h actual %0h", $realtime, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // result monitor: compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin
        icmp_summary_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_summaries.size() == 0)
            begin
                $display("%0t unexpected result word: expected none actual type %0h",
                         $realtime, msg_type);
                fail_count++;
            end
            else
            begin
                e = awaited_summaries.pop_front();
                check_field("msg_type", 32'(e.msg_type), 32'(msg_type));
                check_field("msg_code", 32'(e.msg_code), 32'(msg_code));
                check_field("checksum_field", 32'(e.checksum_field), 32'(checksum_field));
                check_field("rest_of_header", e.rest_of_header, rest_of_header);
                check_field("payload_len", 32'(e.payload_len), 32'(payload_len));
                check_field("status", 32'(e.status), 32'(status));
                check_field("checksum_ok", 32'(e.checksum_ok), 32'(checksum_ok));
                check_field("error_class", 32'(e.error_class), 32'(error_class));
                check_field("info_class", 32'(e.info_class), 32'(info_class));
            end
        end
    end

    // receiver back-pressure, switching between free, coin-flip and sparse
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (rx_pattern)
            RX_FREE:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= ($urandom_range(0, 1) == 1);
            default:  out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        mode_v6   = 1'b0;
        clear_message_shadow();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_directed_frames();
        test_random_frames();
        settle_idle();

        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
